// File: sv/dbc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and lookup tables for the disk block to CHS translator.
// Used by every module of the block; depends on nothing.
package dbc_pkg;

  // Disk geometry and unit count.
  localparam int unsigned SECTORS_PER_TRACK  = 12;
  localparam int unsigned HEADS_PER_CYLINDER = 20;
  localparam int unsigned NUM_UNITS          = 4;

  // Field widths at the ports.
  localparam int unsigned BLKIN_W = 24;
  localparam int unsigned UNIT_W  = 3;
  localparam int unsigned PART_W  = 3;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned CYLO_W  = 9;
  localparam int unsigned HEADO_W = 5;
  localparam int unsigned SECO_W  = 4;

  // Internal widths. An accepted block is below the largest partition size.
  localparam int unsigned MAX_PART_BLOCKS = 97440;
  localparam int unsigned BLK_W   = $clog2(MAX_PART_BLOCKS);
  localparam int unsigned SEC_W   = $clog2(64 + 1);
  localparam int unsigned HD_W    = 5;
  localparam int unsigned CYL_W   = WORD_W;
  localparam int unsigned OFF_W   = 9;

  // Reciprocal division: quotient = (x * RECIP) >> DIV_SHIFT, exact for x < 2**BLK_W
  // and any divisor up to 64.
  localparam int unsigned DIV_SHIFT = BLK_W + 7;
  localparam int unsigned RECIP_W   = DIV_SHIFT + 1;
  localparam int unsigned PROD_W    = BLK_W + RECIP_W;
  localparam int unsigned SPT_RECIP =
    ((1 << DIV_SHIFT) + SECTORS_PER_TRACK - 1) / SECTORS_PER_TRACK;
  localparam int unsigned HPC_RECIP =
    ((1 << DIV_SHIFT) + HEADS_PER_CYLINDER - 1) / HEADS_PER_CYLINDER;

  // Header mark and controller command codes.
  localparam logic [WORD_W-1:0] HDR2_MARK     = 16'o170000;
  localparam logic [WORD_W-1:0] CMD_READ      = 16'o070000;
  localparam logic [WORD_W-1:0] CMD_WRITE     = 16'o130000;
  localparam logic [WORD_W-1:0] CMD_WCHECK    = 16'o071000;
  localparam logic [WORD_W-1:0] CMD_RAW_READ  = 16'o060000;
  localparam logic [WORD_W-1:0] CMD_RAW_WRITE = 16'o110000;

  // Interleave table covers one track of twelve sectors.
  localparam int unsigned ILV_SECTORS = 12;

  // Request after the range check.
  typedef struct packed {
    logic             err;
    logic [BLK_W-1:0] blk;
    logic [OFF_W-1:0] off;
    logic             ilv;
    logic             raw;
    logic             rd;
    logic             wchk;
  } chk_t;

  // Request after geometry translation.
  typedef struct packed {
    logic             err;
    logic [CYL_W-1:0] cyl;
    logic [HD_W-1:0]  hd;
    logic [SEC_W-1:0] sec;
    logic             raw;
    logic             rd;
    logic             wchk;
  } geo_t;

  // Partition size in blocks.
  function automatic logic [BLKIN_W-1:0] part_blocks(input logic [PART_W-1:0] p);
    logic [BLKIN_W-1:0] r;
    unique case (p)
      3'd0:    r = 24'd10080;
      3'd1:    r = 24'd10080;
      3'd2:    r = 24'd77280;
      3'd3:    r = 24'd97440;
      3'd4:    r = 24'd54000;
      3'd5:    r = 24'd65520;
      3'd6:    r = 24'd31680;
      default: r = 24'd2048;
    endcase
    return r;
  endfunction

  // Partition starting cylinder.
  function automatic logic [OFF_W-1:0] part_cyloff(input logic [PART_W-1:0] p);
    logic [OFF_W-1:0] r;
    unique case (p)
      3'd0:    r = 9'd0;
      3'd1:    r = 9'd42;
      3'd2:    r = 9'd84;
      3'd3:    r = 9'd0;
      3'd4:    r = 9'd180;
      3'd5:    r = 9'd0;
      3'd6:    r = 9'd273;
      default: r = 9'd123;
    endcase
    return r;
  endfunction

  // Three-way interleave; sectors past the table pass through unchanged.
  function automatic logic [SEC_W-1:0] ilv_map(input logic [SEC_W-1:0] s);
    logic [SEC_W-1:0] r;
    unique case (s)
      7'd0:    r = 7'd0;
      7'd1:    r = 7'd4;
      7'd2:    r = 7'd8;
      7'd3:    r = 7'd1;
      7'd4:    r = 7'd5;
      7'd5:    r = 7'd9;
      7'd6:    r = 7'd2;
      7'd7:    r = 7'd6;
      7'd8:    r = 7'd10;
      7'd9:    r = 7'd3;
      7'd10:   r = 7'd7;
      7'd11:   r = 7'd11;
      default: r = s;
    endcase
    return r;
  endfunction

endpackage

// File: sv/disk_block_to_chs_command.sv
`timescale 1ns / 1ps
// Top level of the disk block to cylinder/head/sector translator and command builder.
// Depends on dbc_pkg, dbc_check, dbc_divide and dbc_format.
//
//   Channel | Direction | Beat contents
//   --------+-----------+-----------------------------------------------------------
//   in_     | slave     | block, unit, partition (tdata); request flags (tuser)
//   out_    | master    | cylinder, head, sector, header words, command (tdata);
//           |           | out-of-range flag (tuser)
//
// One request enters per cycle while in_tready is high; its result passes through one stage
// each for the range check, the track quotient, the sector and cylinder quotient,
// the head and interleave, and the header and command formatting.
// Reset is synchronous and active low; it empties every stage.
// Each stage holds its beat while the next stage is full and stalled, so a stall on
// out_tready backs up stage by stage and in_tready falls only when all five are full.
module disk_block_to_chs_command (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [23:0] block_number, [26:24] drive_unit, [29:27] partition, [31:30] zero
  input  logic [31:0] in_tdata,
  // [0] interleave, [1] raw_mode, [2] is_read, [3] write_check
  input  logic [3:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [8:0] cylinder, [13:9] head, [17:14] sector, [33:18] header_word1,
  // [49:34] header_word2, [65:50] header_check, [81:66] command_word, [87:82] zero
  output logic [87:0] out_tdata,
  // [0] out_of_range
  output logic [0:0]  out_tuser
);

  logic          chk_valid, chk_ready;
  dbc_pkg::chk_t chk_data;
  logic          geo_valid, geo_ready;
  dbc_pkg::geo_t geo_data;

  logic [dbc_pkg::CYLO_W-1:0]  res_cyl;
  logic [dbc_pkg::HEADO_W-1:0] res_head;
  logic [dbc_pkg::SECO_W-1:0]  res_sec;
  logic [dbc_pkg::WORD_W-1:0]  res_hw1, res_hw2, res_chk, res_cmd;

  dbc_check u_check (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (in_tvalid),
    .s_ready (in_tready),
    .s_blk   (in_tdata[23:0]),
    .s_unit  (in_tdata[26:24]),
    .s_part  (in_tdata[29:27]),
    .s_ilv   (in_tuser[0]),
    .s_raw   (in_tuser[1]),
    .s_rd    (in_tuser[2]),
    .s_wchk  (in_tuser[3]),
    .m_valid (chk_valid),
    .m_ready (chk_ready),
    .m_data  (chk_data)
  );

  dbc_divide u_divide (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (chk_valid),
    .s_ready (chk_ready),
    .s_data  (chk_data),
    .m_valid (geo_valid),
    .m_ready (geo_ready),
    .m_data  (geo_data)
  );

  dbc_format u_format (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (geo_valid),
    .s_ready (geo_ready),
    .s_data  (geo_data),
    .m_valid (out_tvalid),
    .m_ready (out_tready),
    .m_oor   (out_tuser[0]),
    .m_cyl   (res_cyl),
    .m_head  (res_head),
    .m_sec   (res_sec),
    .m_hw1   (res_hw1),
    .m_hw2   (res_hw2),
    .m_chk   (res_chk),
    .m_cmd   (res_cmd)
  );

  // Pack the result fields from the lowest bit up.
  assign out_tdata = {6'd0, res_cmd, res_chk, res_hw2, res_hw1, res_sec, res_head, res_cyl};

endmodule

// File: sv/dbc_check.sv
`timescale 1ns / 1ps
// First pipeline stage: unit and partition range check, partition offset lookup.
// Depends on dbc_pkg.
module dbc_check (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         s_valid,
  output logic                         s_ready,
  input  logic [dbc_pkg::BLKIN_W-1:0]  s_blk,
  input  logic [dbc_pkg::UNIT_W-1:0]   s_unit,
  input  logic [dbc_pkg::PART_W-1:0]   s_part,
  input  logic                         s_ilv,
  input  logic                         s_raw,
  input  logic                         s_rd,
  input  logic                         s_wchk,
  output logic                         m_valid,
  input  logic                         m_ready,
  output dbc_pkg::chk_t                m_data
);

  logic          valid_r;
  dbc_pkg::chk_t data_r;
  dbc_pkg::chk_t data_nxt;

  // The stage takes a beat when empty or when its contents move on.
  assign s_ready = ~valid_r | m_ready;

  // Reject a unit past the last drive or a block past the partition end.
  always_comb begin
    data_nxt.err  = ({1'b0, s_unit} >= (dbc_pkg::UNIT_W + 1)'(dbc_pkg::NUM_UNITS)) ||
                    (s_blk >= dbc_pkg::part_blocks(s_part));
    data_nxt.blk  = s_blk[dbc_pkg::BLK_W-1:0];
    data_nxt.off  = dbc_pkg::part_cyloff(s_part);
    data_nxt.ilv  = s_ilv;
    data_nxt.raw  = s_raw;
    data_nxt.rd   = s_rd;
    data_nxt.wchk = s_wchk;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s_ready) begin
      valid_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      data_r <= data_nxt;
    end
  end

  assign m_valid = valid_r;
  assign m_data  = data_r;

endmodule

// File: sv/dbc_divide.sv
`timescale 1ns / 1ps
// Three pipeline stages that split a block number into cylinder, head and sector
// by reciprocal multiplication. Depends on dbc_pkg.
module dbc_divide (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          s_valid,
  output logic          s_ready,
  input  dbc_pkg::chk_t s_data,
  output logic          m_valid,
  input  logic          m_ready,
  output dbc_pkg::geo_t m_data
);

  localparam int unsigned BW = dbc_pkg::BLK_W;
  localparam int unsigned PW = dbc_pkg::PROD_W;

  // Stage A holds track = block / sectors per track.
  logic             a_valid_r;
  logic             a_ready;
  dbc_pkg::chk_t    a_req_r;
  logic [BW-1:0]    a_trk_r;
  logic [PW-1:0]    a_prod;

  // Stage B holds the sector and track / heads per cylinder.
  logic             b_valid_r;
  logic             b_ready;
  dbc_pkg::chk_t    b_req_r;
  logic [BW-1:0]    b_trk_r;
  logic [BW-1:0]    b_q_r;
  logic [dbc_pkg::SEC_W-1:0] b_sec_r;
  logic [BW-1:0]    b_rem;
  logic [PW-1:0]    b_prod;

  // Stage C holds the finished geometry.
  logic             c_valid_r;
  logic             c_ready;
  dbc_pkg::geo_t    c_data_r;
  dbc_pkg::geo_t    c_data_nxt;
  logic [BW-1:0]    c_hd;

  assign c_ready = ~c_valid_r | m_ready;
  assign b_ready = ~b_valid_r | c_ready;
  assign a_ready = ~a_valid_r | b_ready;
  assign s_ready = a_ready;

  // Stage A: track by reciprocal multiply.
  assign a_prod = PW'(s_data.blk) * PW'(dbc_pkg::SPT_RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_ready) begin
      a_valid_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && s_valid) begin
      a_req_r <= s_data;
      a_trk_r <= a_prod[dbc_pkg::DIV_SHIFT +: BW];
    end
  end

  // Stage B: sector as remainder, cylinder quotient by reciprocal multiply.
  assign b_rem  = a_req_r.blk - BW'(a_trk_r * BW'(dbc_pkg::SECTORS_PER_TRACK));
  assign b_prod = PW'(a_trk_r) * PW'(dbc_pkg::HPC_RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_ready) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid_r) begin
      b_req_r <= a_req_r;
      b_trk_r <= a_trk_r;
      b_sec_r <= b_rem[dbc_pkg::SEC_W-1:0];
      b_q_r   <= b_prod[dbc_pkg::DIV_SHIFT +: BW];
    end
  end

  // Stage C: head as remainder, cylinder offset, optional interleave.
  assign c_hd = b_trk_r - BW'(b_q_r * BW'(dbc_pkg::HEADS_PER_CYLINDER));

  always_comb begin
    c_data_nxt.err  = b_req_r.err;
    c_data_nxt.cyl  = dbc_pkg::CYL_W'(b_req_r.off) + b_q_r[dbc_pkg::CYL_W-1:0];
    c_data_nxt.hd   = c_hd[dbc_pkg::HD_W-1:0];
    c_data_nxt.sec  = (b_req_r.ilv && (b_sec_r < dbc_pkg::SEC_W'(dbc_pkg::ILV_SECTORS)))
                      ? dbc_pkg::ilv_map(b_sec_r) : b_sec_r;
    c_data_nxt.raw  = b_req_r.raw;
    c_data_nxt.rd   = b_req_r.rd;
    c_data_nxt.wchk = b_req_r.wchk;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (c_ready) begin
      c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready && b_valid_r) begin
      c_data_r <= c_data_nxt;
    end
  end

  assign m_valid = c_valid_r;
  assign m_data  = c_data_r;

endmodule

// File: sv/dbc_format.sv
`timescale 1ns / 1ps
// Last pipeline stage: header words, header checksum and command word, held in
// the output register. Depends on dbc_pkg.
module dbc_format (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          s_valid,
  output logic                          s_ready,
  input  dbc_pkg::geo_t                 s_data,
  output logic                          m_valid,
  input  logic                          m_ready,
  output logic                          m_oor,
  output logic [dbc_pkg::CYLO_W-1:0]    m_cyl,
  output logic [dbc_pkg::HEADO_W-1:0]   m_head,
  output logic [dbc_pkg::SECO_W-1:0]    m_sec,
  output logic [dbc_pkg::WORD_W-1:0]    m_hw1,
  output logic [dbc_pkg::WORD_W-1:0]    m_hw2,
  output logic [dbc_pkg::WORD_W-1:0]    m_chk,
  output logic [dbc_pkg::WORD_W-1:0]    m_cmd
);

  localparam int unsigned WW = dbc_pkg::WORD_W;

  logic          valid_r;
  logic          oor_r;
  logic [dbc_pkg::CYLO_W-1:0]  cyl_r;
  logic [dbc_pkg::HEADO_W-1:0] head_r;
  logic [dbc_pkg::SECO_W-1:0]  sec_r;
  logic [WW-1:0] hw1_r, hw2_r, chk_r, cmd_r;
  logic [WW-1:0] hw1, hw2, chk, code, cmd;

  assign s_ready = ~valid_r | m_ready;

  // Header words and their negated-sum check.
  assign hw1 = (WW'(s_data.hd) << 8) + s_data.cyl;
  assign hw2 = dbc_pkg::HDR2_MARK | WW'(s_data.sec);
  assign chk = WW'(0) - hw1 - hw2;

  // Command code; write check applies only to a normal write.
  always_comb begin
    priority if (s_data.raw) begin
      code = s_data.rd ? dbc_pkg::CMD_RAW_READ : dbc_pkg::CMD_RAW_WRITE;
    end else if (s_data.rd) begin
      code = dbc_pkg::CMD_READ;
    end else begin
      code = s_data.wchk ? dbc_pkg::CMD_WCHECK : dbc_pkg::CMD_WRITE;
    end
  end

  assign cmd = code | (WW'(s_data.sec) << 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s_ready) begin
      valid_r <= s_valid;
    end
  end

  // A rejected request carries only its flag; every other field is zero.
  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      oor_r  <= s_data.err;
      cyl_r  <= s_data.err ? '0 : s_data.cyl[dbc_pkg::CYLO_W-1:0];
      head_r <= s_data.err ? '0 : s_data.hd[dbc_pkg::HEADO_W-1:0];
      sec_r  <= s_data.err ? '0 : s_data.sec[dbc_pkg::SECO_W-1:0];
      hw1_r  <= s_data.err ? '0 : hw1;
      hw2_r  <= s_data.err ? '0 : hw2;
      chk_r  <= s_data.err ? '0 : chk;
      cmd_r  <= s_data.err ? '0 : cmd;
    end
  end

  assign m_valid = valid_r;
  assign m_oor   = oor_r;
  assign m_cyl   = cyl_r;
  assign m_head  = head_r;
  assign m_sec   = sec_r;
  assign m_hw1   = hw1_r;
  assign m_hw2   = hw2_r;
  assign m_chk   = chk_r;
  assign m_cmd   = cmd_r;

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// Testbench for the disk block to cylinder/head/sector translator and command builder.
// Drives request beats with bursty gaps, stalls the result side, and checks every
// result beat against its own geometry predictor. Depends on dbc_pkg and the RTL.
module testbench;

  // Request beat as it travels on in_tdata and in_tuser.
  typedef struct packed {
    logic [1:0]  pad;
    logic [2:0]  part;
    logic [2:0]  unit;
    logic [23:0] blk;
  } req_data_t;

  typedef struct packed {
    logic wchk;
    logic rd;
    logic raw;
    logic ilv;
  } req_flags_t;

  typedef struct packed {
    req_flags_t flags;
    req_data_t  data;
  } req_t;

  // Result beat as it travels on out_tdata.
  typedef struct packed {
    logic [5:0]  pad;
    logic [15:0] cmd;
    logic [15:0] ck;
    logic [15:0] h2;
    logic [15:0] h1;
    logic [3:0]  sec;
    logic [4:0]  hd;
    logic [8:0]  cyl;
  } chs_word_t;

  typedef struct packed {
    logic      oor;
    chs_word_t word;
  } chs_t;

  typedef enum logic [1:0] {RX_OPEN, RX_SPARSE, RX_DENSE, RX_PERIODIC} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [3:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [87:0] out_tdata;
  logic [0:0]  out_tuser;

  // Partition geometry and the three-way interleave of one track.
  int unsigned part_size [8] = '{10080, 10080, 77280, 97440, 54000, 65520, 31680, 2048};
  int unsigned part_base [8] = '{0, 42, 84, 0, 180, 0, 273, 123};
  int unsigned ilv3 [12] = '{0, 4, 8, 1, 5, 9, 2, 6, 10, 3, 7, 11};

  req_t        req_pending_q[$];
  chs_t        chs_expected_q[$];
  req_t        req_on_bus;
  int          req_total = 0;
  int          beats_sent = 0;
  int          fail_count = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  rx_mode_t    rx_mode = RX_OPEN;
  int          rx_mode_left = 0;
  int          rx_cycle = 0;

  disk_block_to_chs_command u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Expected translation of one request.
  function automatic chs_t chs_predict(input req_t r);
    chs_t        res;
    int unsigned blk;
    int unsigned trk;
    int unsigned cyl;
    int unsigned hd;
    int unsigned sec;
    logic [15:0] w1;
    logic [15:0] w2;
    logic [15:0] code;
    res = '0;
    blk = r.data.blk;
    if (r.data.unit >= dbc_pkg::NUM_UNITS || blk >= part_size[r.data.part]) begin
      res.oor = 1'b1;
      return res;
    end
    trk = blk / dbc_pkg::SECTORS_PER_TRACK;
    cyl = part_base[r.data.part] + trk / dbc_pkg::HEADS_PER_CYLINDER;
    hd  = trk % dbc_pkg::HEADS_PER_CYLINDER;
    sec = blk % dbc_pkg::SECTORS_PER_TRACK;
    if (r.flags.ilv && sec < 12)
      sec = ilv3[sec];
    w1 = 16'((hd << 8) + cyl);
    w2 = dbc_pkg::HDR2_MARK | 16'(sec);
    // The write-check flag only matters on a normal write.
    if (r.flags.raw)
      code = r.flags.rd ? dbc_pkg::CMD_RAW_READ : dbc_pkg::CMD_RAW_WRITE;
    else if (r.flags.rd)
      code = dbc_pkg::CMD_READ;
    else
      code = r.flags.wchk ? dbc_pkg::CMD_WCHECK : dbc_pkg::CMD_WRITE;
    res.word.cyl = 9'(cyl);
    res.word.hd  = 5'(hd);
    res.word.sec = 4'(sec);
    res.word.h1  = w1;
    res.word.h2  = w2;
    res.word.ck  = 16'(~(w1 + w2) + 16'd1);
    res.word.cmd = code | 16'(sec << 1);
    return res;
  endfunction

  function automatic req_t req_make(input int unsigned blk, input int unsigned unit,
                                    input int unsigned part, input logic [3:0] flags);
    req_t r;
    r.data.pad  = '0;
    r.data.blk  = 24'(blk);
    r.data.unit = 3'(unit);
    r.data.part = 3'(part);
    r.flags     = flags;
    return r;
  endfunction

  function automatic void field_check(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Sender: bursts of beats separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        chs_expected_q.push_back(chs_predict(req_on_bus));
        beats_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (req_pending_q.size() > 0) begin
          req_on_bus = req_pending_q.pop_front();
          in_tdata  <= req_on_bus.data;
          in_tuser  <= req_on_bus.flags;
          in_tvalid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result beat and drives a stall pattern whose mode changes at random.
  always @(posedge clk) begin
    chs_t want;
    chs_t got;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.oor  = out_tuser[0];
        got.word = out_tdata;
        if (chs_expected_q.size() == 0) begin
          $error("result beat arrived with no request outstanding");
          fail_count++;
        end else begin
          want = chs_expected_q.pop_front();
          field_check("out_of_range", want.oor, got.oor);
          field_check("cylinder", want.word.cyl, got.word.cyl);
          field_check("head", want.word.hd, got.word.hd);
          field_check("sector", want.word.sec, got.word.sec);
          field_check("header_word1", want.word.h1, got.word.h1);
          field_check("header_word2", want.word.h2, got.word.h2);
          field_check("header_check", want.word.ck, got.word.ck);
          field_check("command_word", want.word.cmd, got.word.cmd);
          field_check("tdata padding", 16'(want.word.pad), 16'(got.word.pad));
        end
      end
      if (rx_mode_left == 0) begin
        rx_mode      = rx_mode_t'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(20, 200);
      end else begin
        rx_mode_left--;
      end
      rx_cycle++;
      case (rx_mode)
        RX_OPEN:     out_tready <= 1'b1;
        RX_SPARSE:   out_tready <= ($urandom_range(0, 9) < 3);
        RX_DENSE:    out_tready <= ($urandom_range(0, 9) < 8);
        default:     out_tready <= ((rx_cycle % 5) < 2);
      endcase
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int unsigned sel;
    int unsigned unit;
    int unsigned part;
    int unsigned blk;
    // Directed: block 0 of partition 0, last block of every partition, boundaries, bad units,
    // every command combination with the interleave on.
    req_pending_q.push_back(req_make(0, 0, 0, 4'b0100));
    for (int p = 0; p < 8; p++)
      req_pending_q.push_back(req_make(part_size[p] - 1, p % 4, p, 4'(p + 8)));
    req_pending_q.push_back(req_make(part_size[3], 0, 3, 4'b0000));
    req_pending_q.push_back(req_make(part_size[7], 1, 7, 4'b0101));
    req_pending_q.push_back(req_make(24'hFFFFFF, 2, 3, 4'b1111));
    req_pending_q.push_back(req_make(777, 3, 2, 4'b0001));
    req_pending_q.push_back(req_make(777, 4, 2, 4'b0001));
    req_pending_q.push_back(req_make(5, 7, 5, 4'b1010));
    for (int f = 0; f < 8; f++)
      req_pending_q.push_back(req_make(12 * (f + 3) + f + 4, f % 4, 3, 4'((f << 1) | 1)));

    // Random: mostly valid requests, plus bad units, edges and wild blocks.
    for (int i = 0; i < 1330; i++) begin
      sel  = $urandom_range(0, 99);
      unit = $urandom_range(0, 3);
      part = $urandom_range(0, 7);
      blk  = $urandom_range(0, part_size[part] - 1);
      if (sel >= 70 && sel < 80)
        unit = $urandom_range(0, 7);
      else if (sel >= 80 && sel < 88)
        blk = part_size[part] - 2 + $urandom_range(0, 3);
      else if (sel >= 88)
        blk = $urandom();
      req_pending_q.push_back(req_make(blk, unit, part, 4'($urandom_range(0, 15))));
    end
    req_total = req_pending_q.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (beats_sent < req_total || chs_expected_q.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #1000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: files.f
sv/dbc_pkg.sv
sv/dbc_check.sv
sv/dbc_divide.sv
sv/dbc_format.sv
sv/disk_block_to_chs_command.sv
test/testbench.sv
